/* design/nsqrt_pkg.sv */
package nsqrt_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int RADICAND_W = 32;
	localparam int ROOT_W     = 25;
	localparam int ITER_W     = 6;
	localparam int TOL_W      = 5;

	localparam int DIVIDEND_W = RADICAND_W + FRAC_BITS;
	localparam int GUESS_W    = RADICAND_W + 1;
	localparam int CNT_W      = $clog2(DIVIDEND_W + 1);

	localparam int IN_DATA_W  = RADICAND_W;
	localparam int OUT_DATA_W = ((ROOT_W + ITER_W + 1 + 7) / 8) * 8;

	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = ITER_W;

	localparam logic [CFG_INDEX_W-1:0] REG_TOLERANCE_SHIFT = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_MAX_ITERATIONS  = 1'b1;

	localparam logic [TOL_W-1:0]  TOL_RESET      = TOL_W'(17);
	localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(32);

	localparam logic [GUESS_W-1:0] GUESS_ONE = GUESS_W'(1) << FRAC_BITS;
	localparam logic [ROOT_W-1:0]  ROOT_MAX  = {ROOT_W{1'b1}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_DIVIDE,
		ST_UPDATE,
		ST_CHECK,
		ST_PUBLISH
	} state_t;

	typedef struct packed {
		logic                  start;
		logic [DIVIDEND_W-1:0] dividend;
		logic [GUESS_W-1:0]    divisor;
	} div_req_t;

endpackage

/* design/newton_square_root.sv */
// Square root of an unsigned Q16.16 radicand by Newton iteration, starting from a guess of 1.0
// and stopping once a step changes the guess by no more than the guess shifted right by
// tolerance_shift, or after max_iterations steps (0 acts as 1); not_converged is raised when the
// last step missed that bound. A zero radicand is published without any Newton step.
// Otherwise each Newton step runs the shared restoring divider, which yields one quotient
// bit per cycle over the 48-bit dividend. One item is worked on at a time; the next is
// taken while the previous result waits on the output.
module newton_square_root (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [nsqrt_pkg::IN_DATA_W-1:0]     s_tdata,   // radicand
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [nsqrt_pkg::OUT_DATA_W-1:0]    m_tdata,   // root, iterations_used, not_converged
	input  logic                                cfg_we,
	input  logic [nsqrt_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [nsqrt_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import nsqrt_pkg::*;

	state_t state_q;
	state_t state_d;

	logic [TOL_W-1:0]      tol_q;
	logic [ITER_W-1:0]     max_iter_q;

	logic [RADICAND_W-1:0] x_q;
	logic [GUESS_W-1:0]    y_q;
	logic [GUESS_W-1:0]    old_y_q;
	logic [ITER_W-1:0]     steps_q;
	logic [ITER_W-1:0]     limit_q;
	logic                  conv_q;

	logic                  m_tvalid_q;
	logic [OUT_DATA_W-1:0] m_tdata_q;

	div_req_t              div_req;
	logic                  div_done;
	logic [DIVIDEND_W-1:0] div_quot;

	logic                  in_fire;
	logic                  publish;
	logic [DIVIDEND_W:0]   sum;
	logic [GUESS_W-1:0]    diff;
	logic                  met;
	logic [ROOT_W-1:0]     root_sat;

	nsqrt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q      <= TOL_RESET;
			max_iter_q <= MAX_ITER_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TOLERANCE_SHIFT: tol_q      <= cfg_data[TOL_W-1:0];
				REG_MAX_ITERATIONS:  max_iter_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		sum      = {1'b0, div_quot} + (DIVIDEND_W + 1)'(y_q);
		diff     = (y_q > old_y_q) ? (y_q - old_y_q) : (old_y_q - y_q);
		met      = diff <= (y_q >> tol_q);
		root_sat = (y_q > GUESS_W'(ROOT_MAX)) ? ROOT_MAX : y_q[ROOT_W-1:0];
		in_fire  = s_tvalid && s_tready;
		publish  = (state_q == ST_PUBLISH) && (!m_tvalid_q || m_tready);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					state_d = (s_tdata[RADICAND_W-1:0] == '0) ? ST_PUBLISH : ST_START;
				end
			end
			ST_START: state_d = ST_DIVIDE;
			ST_DIVIDE: begin
				if (div_done) begin
					state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: state_d = ST_CHECK;
			ST_CHECK: begin
				state_d = (met || steps_q == limit_q) ? ST_PUBLISH : ST_START;
			end
			ST_PUBLISH: begin
				if (publish) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready         = state_q == ST_IDLE;
		div_req.start    = state_q == ST_START;
		div_req.dividend = {x_q, FRAC_BITS'(0)};
		div_req.divisor  = (y_q == '0) ? GUESS_W'(1) : y_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (publish) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			x_q     <= s_tdata[RADICAND_W-1:0];
			steps_q <= '0;
			limit_q <= (max_iter_q == '0) ? ITER_W'(1) : max_iter_q;
			if (s_tdata[RADICAND_W-1:0] == '0) begin
				y_q    <= '0;
				conv_q <= 1'b1;
			end else begin
				y_q    <= GUESS_ONE;
				conv_q <= 1'b0;
			end
		end
		if (state_q == ST_UPDATE) begin
			old_y_q <= y_q;
			y_q     <= sum[GUESS_W:1];
			steps_q <= steps_q + ITER_W'(1);
		end
		if (state_q == ST_CHECK) begin
			conv_q <= met;
		end
		if (publish) begin
			m_tdata_q <= OUT_DATA_W'({!conv_q, steps_q, root_sat});
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_div_done_in_divide: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIVIDE)
		else $error("divider finished outside the divide phase");

	a_steps_within_limit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CHECK |-> steps_q != '0 && steps_q <= limit_q)
		else $error("step count outside the limit");

	a_zero_guess_no_steps: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PUBLISH && y_q == '0 |-> steps_q == '0 && conv_q)
		else $error("zero root after Newton steps");

	a_publish_from_check: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == ST_PUBLISH) |->
			$past(state_q) == ST_CHECK || $past(state_q) == ST_IDLE)
		else $error("result published from an unexpected phase");
`endif

endmodule

/* design/nsqrt_div.sv */
module nsqrt_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  nsqrt_pkg::div_req_t             req,
	output logic                            done,
	output logic [nsqrt_pkg::DIVIDEND_W-1:0] quotient
);
	import nsqrt_pkg::*;

	logic [GUESS_W-1:0]    rem_q;
	logic [GUESS_W-1:0]    den_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [GUESS_W:0]      trial;
	logic [GUESS_W:0]      trial_sub;
	logic                  fits;

	always_comb begin
		trial     = {rem_q, quo_q[DIVIDEND_W-1]};
		trial_sub = trial - {1'b0, den_q};
		fits      = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.divisor;
			quo_q <= req.dividend;
		end else if (busy_q) begin
			rem_q <= fits ? trial_sub[GUESS_W-1:0] : trial[GUESS_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* test/newton_square_root_test.sv */
`timescale 1ns / 100ps

module newton_square_root_test;
	import nsqrt_pkg::*;

	typedef struct packed {
		logic              nc;
		logic [ITER_W-1:0] iters;
		logic [ROOT_W-1:0] root;
	} root_result_t;

	typedef enum logic [1:0] {
		ROW_SETTINGS,
		ROW_PREDICTED,
		ROW_TYPED
	} row_kind_t;

	typedef struct packed {
		row_kind_t              kind;
		logic [RADICAND_W-1:0]  radicand;
		logic [CFG_DATA_W-1:0]  tol;
		logic [CFG_DATA_W-1:0]  lim;
		root_result_t           want;
	} row_t;

	localparam int PHASES      = 25;
	localparam int PHASE_ITEMS = 50;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_DATA_W-1:0]   s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_DATA_W-1:0]  m_tdata;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	logic [TOL_W-1:0]  tol_shift = TOL_RESET;
	logic [ITER_W-1:0] iter_limit = MAX_ITER_RESET;
	bit                calm = 1'b0;
	root_result_t      pending_roots [$];
	int                requests = 0;
	int                results = 0;
	int                unconverged = 0;
	int                settings_applied = 0;
	int                errors = 0;

	row_t plan [0:20] = '{
		'{ROW_TYPED,     32'h0000_0000, 6'd0,  6'd0,  '{1'b0, 6'd0, 25'h0000000}},
		'{ROW_TYPED,     32'h0001_0000, 6'd0,  6'd0,  '{1'b0, 6'd1, 25'h0010000}},
		'{ROW_PREDICTED, 32'h0000_0001, 6'd0,  6'd0,  '0},
		'{ROW_PREDICTED, 32'hFFFF_FFFF, 6'd0,  6'd0,  '0},
		'{ROW_PREDICTED, 32'h0004_0000, 6'd0,  6'd0,  '0},
		'{ROW_PREDICTED, 32'h0002_0000, 6'd0,  6'd0,  '0},
		'{ROW_SETTINGS,  32'h0000_0000, 6'd17, 6'd0,  '0},
		'{ROW_TYPED,     32'hFFFF_FFFF, 6'd0,  6'd0,  '{1'b1, 6'd1, 25'h1FFFFFF}},
		'{ROW_TYPED,     32'h0001_0000, 6'd0,  6'd0,  '{1'b0, 6'd1, 25'h0010000}},
		'{ROW_SETTINGS,  32'h0000_0000, 6'd31, 6'd63, '0},
		'{ROW_PREDICTED, 32'hFFFF_FFFF, 6'd0,  6'd0,  '0},
		'{ROW_PREDICTED, 32'h0000_0003, 6'd0,  6'd0,  '0},
		'{ROW_PREDICTED, 32'h1234_5678, 6'd0,  6'd0,  '0},
		'{ROW_SETTINGS,  32'h0000_0000, 6'd0,  6'd63, '0},
		'{ROW_PREDICTED, 32'hFFFF_FFFF, 6'd0,  6'd0,  '0},
		'{ROW_PREDICTED, 32'h0000_0001, 6'd0,  6'd0,  '0},
		'{ROW_SETTINGS,  32'h0000_0000, 6'd0,  6'd1,  '0},
		'{ROW_TYPED,     32'h0004_0000, 6'd0,  6'd0,  '{1'b0, 6'd1, 25'h0028000}},
		'{ROW_SETTINGS,  32'h0000_0000, 6'd17, 6'd32, '0},
		'{ROW_PREDICTED, 32'h8000_0000, 6'd0,  6'd0,  '0},
		'{ROW_PREDICTED, 32'h0000_0100, 6'd0,  6'd0,  '0}
	};

	newton_square_root dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // radicand
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // root, iterations_used, not_converged
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic root_result_t newton_root(input logic [RADICAND_W-1:0] x,
		input logic [TOL_W-1:0] tol, input logic [ITER_W-1:0] lim);
		root_result_t r;
		logic [63:0]  y;
		logic [63:0]  prev;
		logic [63:0]  quot;
		logic [63:0]  delta;
		int           steps_allowed;
		int           steps;
		bit           met;
		r = '0;
		if (x == '0)
			return r;
		steps_allowed = (lim == '0) ? 1 : int'(lim);
		y = 64'd1 << FRAC_BITS;
		steps = 0;
		met = 1'b0;
		while (!met && steps < steps_allowed) begin
			prev = y;
			quot = ({32'd0, x} << FRAC_BITS) / ((prev == 64'd0) ? 64'd1 : prev);
			y = (quot + prev) >> 1;
			steps++;
			delta = (y > prev) ? y - prev : prev - y;
			if (delta <= (y >> tol))
				met = 1'b1;
		end
		r.root = (y > 64'(ROOT_MAX)) ? ROOT_MAX : y[ROOT_W-1:0];
		r.iters = steps[ITER_W-1:0];
		r.nc = !met;
		return r;
	endfunction

	function automatic logic [RADICAND_W-1:0] draw_radicand();
		logic [31:0] k;
		logic [31:0] x;
		k = $urandom_range(0, 65535);
		case ($urandom_range(0, 7))
			0: x = $urandom;
			1: x = $urandom >> $urandom_range(0, 31);
			2: x = 32'd1 << $urandom_range(0, 31);
			3: x = k * k;
			4: x = {16'hFFFF, k[15:0]};
			5: x = $urandom_range(0, 15);
			6: x = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
			default: x = $urandom & $urandom;
		endcase
		return x;
	endfunction

	task automatic apply_settings(input logic [CFG_DATA_W-1:0] tol_value,
		input logic [CFG_DATA_W-1:0] lim_value);
		cfg_we <= 1'b1;
		cfg_index <= REG_TOLERANCE_SHIFT;
		cfg_data <= tol_value;
		@(posedge clk);
		cfg_index <= REG_MAX_ITERATIONS;
		cfg_data <= lim_value;
		@(posedge clk);
		cfg_we <= 1'b0;
		tol_shift = tol_value[TOL_W-1:0];
		iter_limit = lim_value[ITER_W-1:0];
		settings_applied++;
	endtask

	task automatic send_request(input logic [RADICAND_W-1:0] x, input root_result_t want);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= x;
		do @(posedge clk); while (!s_tready);
		pending_roots.push_back(want);
		requests++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_roots.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] tol_value;
		logic [CFG_DATA_W-1:0] lim_value;
		logic [RADICAND_W-1:0] x;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_SETTINGS) begin
				drain();
				apply_settings(plan[i].tol, plan[i].lim);
			end else if (plan[i].kind == ROW_TYPED) begin
				send_request(plan[i].radicand, plan[i].want);
			end else begin
				send_request(plan[i].radicand,
					newton_root(plan[i].radicand, tol_shift, iter_limit));
			end
		end
		for (int phase = 0; phase < PHASES; phase++) begin
			drain();
			case ($urandom_range(0, 4))
				0: begin
					tol_value = CFG_DATA_W'($urandom_range(0, 63));
					lim_value = CFG_DATA_W'($urandom_range(0, 63));
				end
				1: begin
					tol_value = $urandom_range(0, 1) ? 6'h1F : 6'h00;
					tol_value[5] = 1'($urandom_range(0, 1));
					case ($urandom_range(0, 2))
						0: lim_value = 6'd0;
						1: lim_value = 6'd1;
						default: lim_value = 6'd63;
					endcase
				end
				default: begin
					tol_value = CFG_DATA_W'($urandom_range(8, 24));
					lim_value = CFG_DATA_W'($urandom_range(6, 40));
				end
			endcase
			apply_settings(tol_value, lim_value);
			calm = ($urandom_range(0, 3) == 0);
			repeat (PHASE_ITEMS) begin
				x = draw_radicand();
				send_request(x, newton_root(x, tol_shift, iter_limit));
			end
		end
		drain();
		repeat (3400) @(posedge clk);
		$display("%0d requests over %0d register settings, %0d results checked",
			requests, settings_applied, results);
		$display("%0d results hit the step limit, %0d errors", unconverged, errors);
		if (errors == 0) begin
			$display("newton_square_root_test: done, clean");
		end else begin
			$display("newton_square_root_test: done, errors");
		end
		$finish;
	end

	initial begin
		root_result_t got;
		root_result_t want;
		int stall;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = calm ? 0 : $urandom_range(0, 3);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			got = m_tdata;
			results++;
			if (got.nc)
				unconverged++;
			if (pending_roots.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("%t: result with no request outstanding: root %h iters %0d nc %b",
						$realtime, got.root, got.iters, got.nc);
			end else begin
				want = pending_roots.pop_front();
				if (got.root !== want.root || got.iters !== want.iters || got.nc !== want.nc) begin
					errors++;
					if (errors <= 10)
						$display("%t: mismatch: root %h/%h iters %0d/%0d nc %b/%b (expected/actual)",
							$realtime, want.root, got.root, want.iters, got.iters,
							want.nc, got.nc);
				end
			end
		end
	end

	initial begin
		#200_000_000;
		$display("newton_square_root_test: done, errors");
		$finish;
	end

endmodule
